// File: rtl/tdl_pkg.sv
// shared types and constants for the travel direction latch
package tdl_pkg;

   // travel direction codes
   typedef enum logic [1:0] {
      DIR_UNKNOWN = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_TOLERANCE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_CYCLES  = 2'd2;

   // register reset values
   localparam logic [14:0] MIN_SPEED_RST       = 15'd80;
   localparam logic [31:0] GOAL_TOL_SQ_RST     = 32'd250000;  // 500 mm squared
   localparam logic [7:0]  CONFIRM_CYCLES_RST  = 8'd5;

   // field widths
   localparam int SPEED_W = 16;
   localparam int POS_W   = 24;

   // live configuration seen by the datapath
   typedef struct packed {
      logic [14:0] min_speed;
      logic [31:0] goal_tol_sq;
      logic [7:0]  confirm_cycles;
   } cfg_type;

   // result of one request
   typedef struct packed {
      dir_type latched_dir;
      logic    new_goal;
      logic    dir_taken;
      logic    confirmed_flip;
   } rsp_info_type;

endpackage

// File: rtl/tdl_csr.sv
// configuration registers with the goal tolerance kept squared
module tdl_csr
   import tdl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                cfg
);

   logic [14:0] thr_ff, thr_in;
   logic [31:0] tol_sq_ff, tol_sq_in;
   logic [7:0]  confirm_ff, confirm_in;

   // decode writes, square the tolerance as it is written
   always_comb begin
      thr_in     = thr_ff;
      tol_sq_in  = tol_sq_ff;
      confirm_in = confirm_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_SPEED:       thr_in = csr_wr_data[14:0];
            CSR_GOAL_TOLERANCE:  tol_sq_in = 32'(csr_wr_data) * 32'(csr_wr_data);
            CSR_CONFIRM_CYCLES:  confirm_in = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= MIN_SPEED_RST;
         tol_sq_ff  <= GOAL_TOL_SQ_RST;
         confirm_ff <= CONFIRM_CYCLES_RST;
      end else begin
         thr_ff     <= thr_in;
         tol_sq_ff  <= tol_sq_in;
         confirm_ff <= confirm_in;
      end
   end

   assign cfg.min_speed       = thr_ff;
   assign cfg.goal_tol_sq     = tol_sq_ff;
   assign cfg.confirm_cycles  = confirm_ff;

endmodule

// File: rtl/tdl_goal_check.sv
// squared goal displacement compare against the squared tolerance
module tdl_goal_check
   import tdl_pkg::*;
(
   input  logic                    goal_valid,
   input  logic signed [POS_W-1:0] stored_x,
   input  logic signed [POS_W-1:0] stored_y,
   input  logic signed [POS_W-1:0] target_x,
   input  logic signed [POS_W-1:0] target_y,
   input  logic [31:0]             goal_tol_sq,
   output logic                    goal_moved
);

   logic signed [POS_W:0]     dx, dy;
   logic [POS_W:0]            adx, ady;
   logic [2*POS_W+1:0]        sq_x, sq_y;
   logic [2*POS_W+2:0]        dist_sq;

   // displacement magnitudes, one bit wider than a coordinate
   assign dx  = (POS_W+1)'(target_x) - (POS_W+1)'(stored_x);
   assign dy  = (POS_W+1)'(target_y) - (POS_W+1)'(stored_y);
   assign adx = dx[POS_W] ? (~dx + 1'b1) : dx;
   assign ady = dy[POS_W] ? (~dy + 1'b1) : dy;

   // two independent squares, then the sum
   assign sq_x    = (2*POS_W+2)'(adx) * (2*POS_W+2)'(adx);
   assign sq_y    = (2*POS_W+2)'(ady) * (2*POS_W+2)'(ady);
   assign dist_sq = (2*POS_W+3)'(sq_x) + (2*POS_W+3)'(sq_y);

   // no goal held yet counts as a move
   assign goal_moved = !goal_valid || (dist_sq > (2*POS_W+3)'(goal_tol_sq));

endmodule

// File: rtl/tdl_dir_state.sv
// direction state, goal store and per-request update
module tdl_dir_state
   import tdl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      upd,
   input  logic                      in_approach,
   input  logic signed [SPEED_W-1:0] speed,
   input  logic signed [POS_W-1:0]   target_x,
   input  logic signed [POS_W-1:0]   target_y,
   input  cfg_type                   cfg,
   output rsp_info_type              rsp_info
);

   logic                    goal_valid_ff, goal_valid_in;
   logic signed [POS_W-1:0] goal_x_ff, goal_x_in;
   logic signed [POS_W-1:0] goal_y_ff, goal_y_in;
   dir_type                 last_ff, last_in;
   dir_type                 latch_ff, latch_in;
   logic [7:0]              cnt_ff, cnt_in;

   logic                    moved;
   dir_type                 base_last, base_latch, obs, pick;
   logic [7:0]              base_cnt, cnt_inc, need;
   logic signed [SPEED_W:0] spd_ext, thr_pos, thr_neg;
   logic                    opposite, switch_ok;

   tdl_goal_check u_goal_check (
      .goal_valid  (goal_valid_ff),
      .stored_x    (goal_x_ff),
      .stored_y    (goal_y_ff),
      .target_x    (target_x),
      .target_y    (target_y),
      .goal_tol_sq (cfg.goal_tol_sq),
      .goal_moved  (moved)
   );

   // state as seen after a goal change clears it
   assign base_last  = moved ? DIR_UNKNOWN : last_ff;
   assign base_latch = moved ? DIR_UNKNOWN : latch_ff;
   assign base_cnt   = moved ? 8'd0 : cnt_ff;

   // speed classification, forward test wins at zero threshold
   assign spd_ext = (SPEED_W+1)'(speed);
   assign thr_pos = signed'({2'b00, cfg.min_speed});
   assign thr_neg = -thr_pos;
   always_comb begin
      if (spd_ext >= thr_pos) begin
         obs = DIR_FORWARD;
      end else if (spd_ext <= thr_neg) begin
         obs = DIR_REVERSE;
      end else begin
         obs = DIR_UNKNOWN;
      end
   end

   assign pick      = (obs != DIR_UNKNOWN) ? obs : base_last;
   assign cnt_inc   = base_cnt + 8'd1;
   assign need      = (cfg.confirm_cycles == 8'd0) ? 8'd1 : cfg.confirm_cycles;
   assign opposite  = (obs != DIR_UNKNOWN) && (obs != base_latch);
   assign switch_ok = cnt_inc >= need;

   // next state
   always_comb begin
      goal_valid_in = goal_valid_ff | moved;
      goal_x_in     = moved ? target_x : goal_x_ff;
      goal_y_in     = moved ? target_y : goal_y_ff;
      latch_in      = base_latch;
      last_in       = base_last;
      cnt_in        = base_cnt;
      if (!in_approach) begin
         latch_in = DIR_UNKNOWN;
         cnt_in   = 8'd0;
         if (obs != DIR_UNKNOWN) begin
            last_in = obs;
         end
      end else if (base_latch == DIR_UNKNOWN) begin
         if (pick != DIR_UNKNOWN) begin
            latch_in = pick;
            last_in  = pick;
         end
      end else if (opposite) begin
         cnt_in = cnt_inc;
         if (switch_ok) begin
            latch_in = obs;
            last_in  = obs;
            cnt_in   = 8'd0;
         end
      end else begin
         cnt_in = 8'd0;
         if (obs == base_latch) begin
            last_in = obs;
         end
      end
   end

   // result fields
   always_comb begin
      rsp_info.latched_dir    = latch_in;
      rsp_info.new_goal       = moved;
      rsp_info.dir_taken      = in_approach && (base_latch == DIR_UNKNOWN) &&
                                (pick != DIR_UNKNOWN);
      rsp_info.confirmed_flip = in_approach && (base_latch != DIR_UNKNOWN) &&
                                opposite && switch_ok;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_valid_ff <= 1'b0;
         last_ff       <= DIR_UNKNOWN;
         latch_ff      <= DIR_UNKNOWN;
         cnt_ff        <= 8'd0;
      end else if (upd) begin
         goal_valid_ff <= goal_valid_in;
         last_ff       <= last_in;
         latch_ff      <= latch_in;
         cnt_ff        <= cnt_in;
      end
   end

   // stored goal, only meaningful once goal_valid_ff is set
   always_ff @(posedge clock) begin
      if (upd) begin
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
      end
   end

   // outside the approach zone the latch ends up unknown
   a_clear_outside: assert property (@(posedge clock) disable iff (reset)
      upd && !in_approach |=> latch_ff == DIR_UNKNOWN)
      else $error("latch not cleared outside approach zone");

   // a confirmed switch restarts the opposite count
   a_switch_count: assert property (@(posedge clock) disable iff (reset)
      upd && rsp_info.confirmed_flip |=> cnt_ff == 8'd0)
      else $error("opposite count not cleared after switch");

   // a new goal is held afterwards
   a_goal_held: assert property (@(posedge clock) disable iff (reset)
      upd && moved |=> goal_valid_ff)
      else $error("goal not held after change");

   // an acquired latch also becomes the last motion
   a_acquire_track: assert property (@(posedge clock) disable iff (reset)
      upd && rsp_info.dir_taken |=> latch_ff != DIR_UNKNOWN && latch_ff == last_ff)
      else $error("acquired latch not tracked as last motion");

endmodule

// File: rtl/travel_direction_latch_core.sv
// travel direction latch top level: request register, update, response register
// a request taken into the request register has its response captured in the response register
// throughput: one request per cycle while the response side does not stall; the state update
//   is combinational through the goal displacement squares and the direction logic
// the request register can take one request while a response waits, so one request can enter under stall
// reset clears valids and direction state and loads register defaults (80, 500, 5)
module travel_direction_latch_core
   import tdl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_in_approach,
   input  logic signed [SPEED_W-1:0] req_speed,
   input  logic signed [POS_W-1:0]   req_target_x,
   input  logic signed [POS_W-1:0]   req_target_y,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_latched_dir,
   output logic                      rsp_new_goal,
   output logic                      rsp_dir_taken,
   output logic                      rsp_confirmed_flip,
   // configuration writes
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data
);

   cfg_type                 cfg;
   rsp_info_type            info;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_approach_ff;
   logic signed [SPEED_W-1:0] s1_speed_ff;
   logic signed [POS_W-1:0] s1_x_ff, s1_y_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_info_type            rsp_ff;

   logic                    req_take, advance;

   tdl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tdl_dir_state u_dir_state (
      .clock       (clock),
      .reset       (reset),
      .upd         (advance),
      .in_approach (s1_approach_ff),
      .speed       (s1_speed_ff),
      .target_x    (s1_x_ff),
      .target_y    (s1_y_ff),
      .cfg         (cfg),
      .rsp_info    (info)
   );

   // handshake: request moves on when the response register is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_approach_ff <= req_in_approach;
         s1_speed_ff    <= req_speed;
         s1_x_ff        <= req_target_x;
         s1_y_ff        <= req_target_y;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= info;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_latched_dir    = rsp_ff.latched_dir;
   assign rsp_new_goal       = rsp_ff.new_goal;
   assign rsp_dir_taken      = rsp_ff.dir_taken;
   assign rsp_confirmed_flip = rsp_ff.confirmed_flip;

endmodule

// File: bench/travel_direction_latch_core_tb.sv
// testbench for the travel direction latch core: scoreboard, drivers and stimulus
`timescale 1ns / 1ps

module travel_direction_latch_core_tb;
   import tdl_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [15:0]            GOAL_TOL_RST     = 16'd500;

   // one controller cycle as carried by a request
   typedef struct {
      logic               in_approach;
      logic signed [15:0] speed;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
   } cycle_sample_type;

   // own copy of the latch state, predicts the response of each request
   class latch_scoreboard;
      logic [14:0]        speed_thr;
      logic [15:0]        goal_tol;
      logic [7:0]         confirm;
      bit                 goal_held;
      logic signed [23:0] goal_x;
      logic signed [23:0] goal_y;
      dir_type            motion;
      dir_type            latch;
      logic [7:0]         opposite_run;
      rsp_info_type       pending_latch_q[$];
      int                 mismatches;
      int                 checked;
      int                 goal_changes;
      int                 acquisitions;
      int                 confirmed_flips;

      function new();
         speed_thr       = MIN_SPEED_RST;
         goal_tol        = GOAL_TOL_RST;
         confirm         = CONFIRM_CYCLES_RST;
         goal_held       = 1'b0;
         goal_x          = '0;
         goal_y          = '0;
         motion          = DIR_UNKNOWN;
         latch           = DIR_UNKNOWN;
         opposite_run    = '0;
         mismatches      = 0;
         checked         = 0;
         goal_changes    = 0;
         acquisitions    = 0;
         confirmed_flips = 0;
      endfunction

      function int pending();
         return pending_latch_q.size();
      endfunction

      // register write, unknown index leaves everything alone
      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [15:0] data);
         case (index)
            CSR_MIN_SPEED:       speed_thr = data[14:0];
            CSR_GOAL_TOLERANCE:  goal_tol  = data;
            CSR_CONFIRM_CYCLES:  confirm   = data[7:0];
            default: ;
         endcase
      endfunction

      // forward test first, so a zero threshold makes zero speed forward
      function dir_type classify_speed(logic signed [15:0] spd);
         int s;
         int t;
         s = spd;
         t = int'(speed_thr);
         if (s >= t) return DIR_FORWARD;
         if (s <= -t) return DIR_REVERSE;
         return DIR_UNKNOWN;
      endfunction

      // exact squared distance against squared tolerance
      function bit goal_moved(logic signed [23:0] gx, logic signed [23:0] gy);
         longint dx;
         longint dy;
         longint d2;
         longint t2;
         if (!goal_held) return 1'b1;
         dx = longint'(gx) - longint'(goal_x);
         dy = longint'(gy) - longint'(goal_y);
         d2 = dx * dx + dy * dy;
         t2 = longint'(goal_tol) * longint'(goal_tol);
         return d2 > t2;
      endfunction

      function void note_sample(cycle_sample_type s);
         dir_type      seen;
         dir_type      pick;
         int           need;
         rsp_info_type want;
         want = '0;
         need = (confirm == 8'd0) ? 1 : int'(confirm);

         // new goal clears direction state before the cycle is processed
         if (goal_moved(s.target_x, s.target_y)) begin
            goal_held         = 1'b1;
            goal_x            = s.target_x;
            goal_y            = s.target_y;
            motion            = DIR_UNKNOWN;
            latch             = DIR_UNKNOWN;
            opposite_run      = '0;
            want.new_goal     = 1'b1;
         end

         seen = classify_speed(s.speed);
         if (!s.in_approach) begin
            // outside the zone: latch cleared, motion tracked
            latch        = DIR_UNKNOWN;
            opposite_run = '0;
            if (seen != DIR_UNKNOWN) motion = seen;
         end else if (latch == DIR_UNKNOWN) begin
            // acquire from observed or last motion
            pick = (seen != DIR_UNKNOWN) ? seen : motion;
            if (pick != DIR_UNKNOWN) begin
               latch          = pick;
               motion         = pick;
               want.dir_taken = 1'b1;
            end
         end else if (seen != DIR_UNKNOWN && seen != latch) begin
            // opposite motion must persist before the latch flips
            opposite_run = opposite_run + 8'd1;
            if (int'(opposite_run) >= need) begin
               latch               = seen;
               motion              = seen;
               opposite_run        = '0;
               want.confirmed_flip = 1'b1;
            end
         end else begin
            opposite_run = '0;
            if (seen == latch) motion = seen;
         end

         want.latched_dir = latch;
         pending_latch_q.push_back(want);
      endfunction

      function void check_latch_output(rsp_info_type got);
         rsp_info_type want;
         if (pending_latch_q.size() == 0) begin
            $error("unexpected response: latched_dir %0d with no request outstanding",
                   got.latched_dir);
            mismatches++;
            return;
         end
         want = pending_latch_q.pop_front();
         checked++;
         goal_changes    += want.new_goal;
         acquisitions    += want.dir_taken;
         confirmed_flips += want.confirmed_flip;
         if (got.latched_dir !== want.latched_dir) begin
            $error("latched_dir: expected %0d, actual %0d", want.latched_dir, got.latched_dir);
            mismatches++;
         end
         if (got.new_goal !== want.new_goal) begin
            $error("new_goal: expected %0b, actual %0b", want.new_goal, got.new_goal);
            mismatches++;
         end
         if (got.dir_taken !== want.dir_taken) begin
            $error("dir_taken: expected %0b, actual %0b",
                   want.dir_taken, got.dir_taken);
            mismatches++;
         end
         if (got.confirmed_flip !== want.confirmed_flip) begin
            $error("confirmed_flip: expected %0b, actual %0b",
                   want.confirmed_flip, got.confirmed_flip);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_in_approach = 1'b0;
   logic signed [SPEED_W-1:0] req_speed = '0;
   logic signed [POS_W-1:0]   req_target_x = '0;
   logic signed [POS_W-1:0]   req_target_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_latched_dir;
   logic                      rsp_new_goal;
   logic                      rsp_dir_taken;
   logic                      rsp_confirmed_flip;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wr_data = '0;

   logic            calm = 1'b0;
   latch_scoreboard board;
   int              settings_used = 0;

   travel_direction_latch_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_approach    (req_in_approach),
      .req_speed          (req_speed),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_latched_dir    (rsp_latched_dir),
      .rsp_new_goal       (rsp_new_goal),
      .rsp_dir_taken      (rsp_dir_taken),
      .rsp_confirmed_flip (rsp_confirmed_flip),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // response side: check accepted responses, stall at random
   always @(posedge clock) begin : response_monitor
      rsp_info_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.latched_dir    = dir_type'(rsp_latched_dir);
         got.new_goal       = rsp_new_goal;
         got.dir_taken      = rsp_dir_taken;
         got.confirmed_flip = rsp_confirmed_flip;
         board.check_latch_output(got);
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < 14);
   end

   // present one request and hold it until accepted
   task automatic send_sample(input cycle_sample_type s);
      req_valid       <= 1'b1;
      req_in_approach <= s.in_approach;
      req_speed       <= s.speed;
      req_target_x    <= s.target_x;
      req_target_y    <= s.target_y;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_sample(s);
   endtask

   // random sender idle between requests
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // hold off the sender until every response is back
   task automatic wait_all_done();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (board.pending() != 0);
   endtask

   task automatic send_fixed(input logic app, input logic [15:0] spd,
                             input logic [23:0] tx, input logic [23:0] ty);
      cycle_sample_type s;
      s.in_approach = app;
      s.speed       = spd;
      s.target_x    = tx;
      s.target_y    = ty;
      sender_gap();
      send_sample(s);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      board.set_register(index, data);
   endtask

   // unused upper data bits carry random junk that must be dropped
   task automatic apply_settings(input logic [14:0] thr, input logic [15:0] tol,
                                 input logic [7:0] cc, input bit poke_unused);
      write_csr(CSR_MIN_SPEED, {1'($urandom_range(0, 1)), thr});
      write_csr(CSR_GOAL_TOLERANCE, tol);
      write_csr(CSR_CONFIRM_CYCLES, {8'($urandom), cc});
      if (poke_unused) write_csr(CSR_UNUSED_INDEX, 16'($urandom));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // runs of steady approach and motion with random content, some noisy runs
   task automatic run_random_phase(input int count, input int calm_from, input int calm_to);
      cycle_sample_type s;
      int            run_left;
      int            mode;
      int            need;
      int            thr;
      int            half;
      int            ox;
      int            oy;
      bit            noisy;
      bit            app;
      bit            jump;
      run_left = 0;
      mode     = 0;
      noisy    = 1'b0;
      app      = 1'b0;
      jump     = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (calm_from < calm_to && i == calm_from) calm <= 1'b1;
         if (calm_from < calm_to && i == calm_to) calm <= 1'b0;

         // start of a new run
         if (run_left == 0) begin
            need     = (board.confirm == 8'd0) ? 1 : int'(board.confirm);
            run_left = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 3))
                                                   : int'($urandom_range(need, need + 2));
            noisy    = ($urandom_range(0, 99) < 15);
            app      = ($urandom_range(0, 99) < 70);
            mode     = $urandom_range(0, 99);
            jump     = ($urandom_range(0, 99) < 8);
         end
         run_left--;
         thr  = int'(board.speed_thr);
         half = int'(board.goal_tol) / 2;

         // goal: jitter inside tolerance, or a jump
         if (jump) begin
            jump = 1'b0;
            case ($urandom_range(0, 2))
               0: begin
                  s.target_x = 24'($urandom);
                  s.target_y = 24'($urandom);
               end
               1: begin
                  // exactly on the tolerance circle
                  s.target_x = 24'(board.goal_x + int'(board.goal_tol));
                  s.target_y = board.goal_y;
               end
               default: begin
                  // one millimetre past the tolerance
                  s.target_x = board.goal_x;
                  s.target_y = 24'(board.goal_y - int'(board.goal_tol) - 1);
               end
            endcase
         end else begin
            ox = int'($urandom_range(0, 2 * half)) - half;
            oy = int'($urandom_range(0, 2 * half)) - half;
            s.target_x = 24'(board.goal_x + ox);
            s.target_y = 24'(board.goal_y + oy);
         end

         // speed by run mode
         if (noisy) begin
            s.speed       = 16'($urandom);
            s.in_approach = 1'($urandom);
         end else begin
            s.in_approach = app;
            if (mode < 45)
               s.speed = 16'($urandom_range(thr, 32767));
            else if (mode < 90 || thr == 0)
               s.speed = 16'(-int'($urandom_range(thr, 32768)));
            else
               s.speed = 16'(int'($urandom_range(0, 2 * (thr - 1))) - (thr - 1));
         end

         if (i == count / 2 || $urandom_range(0, 199) == 0)
            wait_all_done();
         else
            sender_gap();
         send_sample(s);
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: acquire from last motion, confirmed switch, goal tolerance edge
      send_fixed(1'b0, 16'sd0, 24'h000000, 24'h000000);
      send_fixed(1'b0, 16'sd200, 24'h000000, 24'h000000);
      send_fixed(1'b1, 16'sd0, 24'h000000, 24'h000000);
      repeat (5) send_fixed(1'b1, 16'h8000, 24'h000000, 24'h000000);
      send_fixed(1'b1, 16'h7fff, 24'h000000, 24'h000000);
      send_fixed(1'b1, 16'sd10, 24'h000000, 24'h000000);
      send_fixed(1'b1, 16'sd80, 24'h7fffff, 24'h800000);
      send_fixed(1'b0, -16'sd80, 24'h7ffed3, 24'h800190);
      send_fixed(1'b0, 16'sd79, 24'h7ffed2, 24'h800190);
      send_fixed(1'b1, -16'sd79, 24'h7ffed2, 24'h800190);
      wait_all_done();

      // zero threshold, zero tolerance, zero confirm count
      apply_settings(15'd0, 16'd0, 8'd0, 1'b1);
      send_fixed(1'b1, 16'sd0, 24'h7ffed2, 24'h800190);
      send_fixed(1'b1, -16'sd1, 24'h7ffed2, 24'h800190);
      send_fixed(1'b1, 16'sd1, 24'h7ffed3, 24'h800190);
      wait_all_done();

      // largest settings
      apply_settings(15'h7fff, 16'hffff, 8'd255, 1'b0);
      send_fixed(1'b1, 16'sd32766, 24'h800000, 24'h7fffff);
      send_fixed(1'b1, -16'sd32767, 24'h80ffff, 24'h7fffff);
      send_fixed(1'b1, 16'h7fff, 24'h80ffff, 24'h7fffff);
      send_fixed(1'b0, 16'h8000, 24'h555555, 24'haaaaaa);
      send_fixed(1'b1, 16'h7fff, 24'h555555, 24'haaaaaa);
      wait_all_done();

      // random phases over several settings
      apply_settings(15'd80, 16'd500, 8'd5, 1'b1);
      run_random_phase(100, 20, 80);
      wait_all_done();
      apply_settings(15'd0, 16'd0, 8'd1, 1'b0);
      run_random_phase(80, 0, 0);
      wait_all_done();
      apply_settings(15'h7fff, 16'hffff, 8'd255, 1'b0);
      run_random_phase(300, 0, 0);
      repeat (3) begin
         wait_all_done();
         apply_settings(15'($urandom_range(0, 2000)), 16'($urandom_range(0, 5000)),
                        8'($urandom_range(1, 12)), 1'b1);
         run_random_phase(90, 0, 0);
      end
      wait_all_done();
      apply_settings(15'd1, 16'd1, 8'd2, 1'b0);
      run_random_phase(60, 0, 0);

      // drain, then idle while watching for stray responses
      wait_all_done();
      repeat (4) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d expected responses never arrived", board.pending());
         board.mismatches++;
      end

      $display("checked %0d responses across %0d register settings", board.checked,
               settings_used);
      $display("seen: %0d goal changes, %0d latch acquisitions, %0d confirmed flips",
               board.goal_changes, board.acquisitions, board.confirmed_flips);
      if (board.mismatches == 0) begin
         $display("** travel_direction_latch_core: PASSED **");
      end else begin
         $display("** travel_direction_latch_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("** travel_direction_latch_core: FAILED **");
      $finish;
   end

endmodule
